FILE: design/rwrt_pkg.sv
// Package for the receive window reorder tracker.
// Holds the transaction payload structs and the sequencer state type.
// No dependencies.
package rwrt_pkg;

  // Field widths of the payload
  localparam int unsigned SeqNoW = 16;

  // Packet transaction: one arriving data packet
  typedef struct packed {
    logic [SeqNoW-1:0] seq_no;
    logic              start_flag;
  } in_t;

  // Result transaction: one ack decision per packet
  typedef struct packed {
    logic              ack_send;
    logic [SeqNoW-1:0] ack_no;
    logic              accepted;
  } out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_WAIT,
    ST_WALK_RD,
    ST_WALK_LOAD,
    ST_WALK,
    ST_DONE
  } state_e;

endpackage

FILE: design/rwrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the received-packet bitmap. No dependencies.
module rwrt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/receive_window_reorder_tracker.sv
// Receive window reorder tracker: receiver side of a sequenced link with cumulative ack.
// Depends on rwrt_pkg (payload structs, state type) and rwrt_ram (bitmap storage).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  : seq_no, start_flag
//   out     | output    | out_valid_o / out_stall_i | out_data_o : ack_send, ack_no, accepted
//
// One packet at a time. A packet outside the window goes from ST_IDLE straight to ST_DONE.
// A packet inside the window is marked in ST_SET_WAIT; the pointer walk then releases
// the run of in-order packets, loading each bitmap word it crosses through ST_WALK_RD
// and ST_WALK_LOAD, and in ST_WALK tests one bitmap bit per cycle on the word held
// from the single RAM read port. After reset a clearing pass writes every bitmap word
// (2048 at the default) with in_stall_o high. A finished result waits in the output
// register; the next packet is taken meanwhile and parks in ST_DONE if it still waits.
module receive_window_reorder_tracker #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rwrt_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rwrt_pkg::out_t out_data_o
);

  import rwrt_pkg::*;

  // Bitmap geometry: words of up to 32 bits, at least two words deep
  localparam int unsigned WordLog = (SEQ_BITS > 5) ? 5 : SEQ_BITS - 1;
  localparam int unsigned WordW   = 1 << WordLog;
  localparam int unsigned AddrW   = SEQ_BITS - WordLog;
  localparam int unsigned Depth   = 1 << AddrW;

  // Window limits
  localparam logic [SEQ_BITS-1:0] RepeatLimit =
    SEQ_BITS'((1 << (SEQ_BITS - 1)) + (1 << (SEQ_BITS - 2)));

  state_e              state_q, state_d;
  logic                started_q, started_d;
  logic [SEQ_BITS-1:0] ne_q, ne_d;
  logic [SEQ_BITS-1:0] seq_q, seq_d;
  logic [WordW-1:0]    word_q, word_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  out_t                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [WordW-1:0]    ram_wdata;
  logic [AddrW-1:0]    ram_raddr;
  logic [WordW-1:0]    ram_rdata;

  logic [SEQ_BITS-1:0] in_seq;
  logic [SEQ_BITS-1:0] fwd_dist;
  logic [SeqNoW-1:0]   ack_now;
  logic [WordLog-1:0]  ne_bit;
  logic [WordW-1:0]    ne_mask;
  logic [WordLog-1:0]  seq_bit;

  // Bitmap storage
  rwrt_ram #(
    .WIDTH (WordW),
    .DEPTH (Depth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Derived values
  assign in_seq   = in_data_i.seq_no[SEQ_BITS-1:0];
  assign fwd_dist = in_seq - ne_q;
  assign ack_now  = SeqNoW'(SEQ_BITS'(ne_q - SEQ_BITS'(1)));
  assign ne_bit   = ne_q[WordLog-1:0];
  assign ne_mask  = WordW'(1) << ne_bit;
  assign seq_bit  = seq_q[WordLog-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    ne_d        = ne_q;
    seq_d       = seq_q;
    word_d      = word_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = ne_q[SEQ_BITS-1:WordLog];
    ram_wdata   = word_q;
    ram_raddr   = ne_q[SEQ_BITS-1:WordLog];

    // Drop the output transaction once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_raddr  = in_seq[SEQ_BITS-1:WordLog];
        if (in_valid_i) begin
          seq_d  = in_seq;
          pend_d = '0;
          if (!started_q && !in_data_i.start_flag) begin
            state_d = ST_DONE;
          end else begin
            started_d = 1'b1;
            if (!fwd_dist[SEQ_BITS-1]) begin
              state_d = ST_SET_WAIT;
            end else begin
              if (fwd_dist > RepeatLimit) begin
                pend_d.ack_send = 1'b1;
                pend_d.ack_no   = ack_now;
              end
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_SET_WAIT: begin
        // Mark the arriving packet in its word
        ram_we    = 1'b1;
        ram_waddr = seq_q[SEQ_BITS-1:WordLog];
        ram_wdata = ram_rdata | (WordW'(1) << seq_bit);
        state_d   = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_LOAD;
      end
      ST_WALK_LOAD: begin
        word_d  = ram_rdata;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if ((word_q & ne_mask) != '0) begin
          // Consume one in-order packet and advance the pointer
          word_d = word_q & ~ne_mask;
          ne_d   = ne_q + SEQ_BITS'(1);
          if (ne_bit == '1) begin
            ram_we    = 1'b1;
            ram_wdata = word_q & ~ne_mask;
            state_d   = ST_WALK_RD;
          end
        end else begin
          // Run ended: write the word back and form the ack
          ram_we          = 1'b1;
          pend_d.ack_send = 1'b1;
          pend_d.ack_no   = ack_now;
          pend_d.accepted = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      started_q   <= 1'b0;
      ne_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      ne_q        <= ne_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    word_q <= word_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_no_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ack_send |-> out_data_o.ack_no == '0)
    else $error("ack number set without ack");

  a_accept_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.ack_send)
    else $error("accepted packet without ack");

  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second packet taken while busy");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK && state_d == ST_WALK |-> (word_q & ne_mask) != '0)
    else $error("walk continued over an unmarked bit");

endmodule

FILE: sim/receive_window_reorder_tracker_test.sv
// Testbench for receive_window_reorder_tracker: drives packet transactions and checks acks.
// Depends on rwrt_pkg for the payload structs and on the block itself; predicts each ack
// from its own copy of the window state held in a small scoreboard class.
module receive_window_reorder_tracker_test;
  import rwrt_pkg::*;

  localparam int unsigned SeqSpace    = 1 << SeqNoW;
  localparam int unsigned HalfSpace   = SeqSpace >> 1;
  localparam int unsigned RepeatLimit = (SeqSpace >> 1) + (SeqSpace >> 2);
  localparam int unsigned RandomPackets = 1700;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned QuietLimit  = 20000;

  // Predict acks from the window state and match them against the block's results
  class ack_scoreboard;
    bit              started;
    logic [SeqNoW-1:0] next_seq;
    bit              seen_map [SeqSpace];
    out_t            expected_acks [$];
    int unsigned     mismatches;

    function new();
      started    = 1'b0;
      next_seq   = '0;
      mismatches = 0;
      foreach (seen_map[i]) seen_map[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_acks.size();
    endfunction

    // Advance the window for one accepted packet and queue the ack it causes
    function void note_packet(in_t pkt);
      logic [SeqNoW-1:0] fwd_dist;
      int unsigned       walked;
      out_t              ack;
      ack = '0;
      if (started || pkt.start_flag) begin
        started = 1'b1;
        fwd_dist = pkt.seq_no - next_seq;
        if (fwd_dist < HalfSpace) begin
          seen_map[pkt.seq_no] = 1'b1;
          walked = 0;
          // Release the run of in-order packets
          while (walked < SeqSpace && seen_map[next_seq]) begin
            seen_map[next_seq] = 1'b0;
            next_seq = next_seq + 1'b1;
            walked++;
          end
          ack.ack_send = 1'b1;
          ack.ack_no   = next_seq - 1'b1;
          ack.accepted = 1'b1;
        end else if (fwd_dist > RepeatLimit) begin
          // Old packet: repeat the last cumulative ack
          ack.ack_send = 1'b1;
          ack.ack_no   = next_seq - 1'b1;
        end
      end
      expected_acks.push_back(ack);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_ack(out_t got);
      out_t want;
      if (expected_acks.size() == 0) begin
        report($sformatf("unexpected ack transaction %p", got));
      end else begin
        want = expected_acks.pop_front();
        if (got.ack_send !== want.ack_send)
          report($sformatf("ack_send got %b want %b", got.ack_send, want.ack_send));
        if (got.ack_no !== want.ack_no)
          report($sformatf("ack_no got %h want %h", got.ack_no, want.ack_no));
        if (got.accepted !== want.accepted)
          report($sformatf("accepted got %b want %b", got.accepted, want.accepted));
      end
    endtask

    task close();
      if (expected_acks.size() != 0)
        report($sformatf("%0d acks never arrived", expected_acks.size()));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_t  in_pkt = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_t out_data_o;

  ack_scoreboard acks = new();
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit long_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  receive_window_reorder_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_pkt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Offer one packet after a random gap and hold it until the block takes it
  task automatic send_packet(in_t pkt);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_pkt   <= pkt;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    acks.note_packet(pkt);
  endtask

  // Send a packet placed at a given distance ahead of the predicted pointer
  task automatic send_ahead(logic [SeqNoW-1:0] fwd_dist, logic start);
    in_t pkt;
    pkt.seq_no     = acks.next_seq + fwd_dist;
    pkt.start_flag = start;
    send_packet(pkt);
  endtask

  // Mostly short reorder distances, with far, dropped, old and wild packets mixed in
  function automatic in_t draw_packet();
    int unsigned       pick;
    logic [SeqNoW-1:0] fwd_dist;
    in_t               pkt;
    pick = $urandom_range(0, 99);
    if (pick < 68)
      fwd_dist = ($urandom_range(0, 3) == 0) ? '0 : SeqNoW'($urandom_range(1, 11));
    else if (pick < 76) fwd_dist = SeqNoW'($urandom_range(12, HalfSpace - 1));
    else if (pick < 84) fwd_dist = SeqNoW'($urandom_range(HalfSpace, RepeatLimit));
    else if (pick < 94) fwd_dist = SeqNoW'($urandom_range(RepeatLimit + 1, SeqSpace - 1));
    else fwd_dist = SeqNoW'($urandom);
    pkt.seq_no     = acks.next_seq + fwd_dist;
    pkt.start_flag = ($urandom_range(0, 19) == 0);
    return pkt;
  endfunction

  // Take ack transactions, stalling before each for a random wait when recv_idle is set, or once for LongHold
  always begin : ack_sink
    int unsigned wait_cycles;
    @(negedge clk_i);
    wait_cycles = recv_idle ? $urandom_range(0, 19) : 0;
    if (long_hold) begin
      long_hold   = 1'b0;
      wait_cycles = LongHold;
    end
    if (wait_cycles > 0) begin
      out_stall <= 1'b1;
      repeat (wait_cycles) @(negedge clk_i);
    end
    out_stall <= 1'b0;
    @(posedge clk_i);
    while (out_valid_o !== 1'b1) @(posedge clk_i);
    acks.check_ack(out_data_o);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    in_t pkt;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Before the start marker: ignored
    pkt = '{seq_no: 16'hFFFF, start_flag: 1'b0};
    send_packet(pkt);
    pkt = '{seq_no: 16'h0000, start_flag: 1'b0};
    send_packet(pkt);
    pkt = '{seq_no: 16'h8000, start_flag: 1'b0};
    send_packet(pkt);
    // Start marker, out of order, duplicate, then release runs
    send_ahead(3, 1'b1);
    send_ahead(1, 1'b0);
    send_ahead(3, 1'b0);
    send_ahead(0, 1'b0);
    send_ahead(0, 1'b0);
    // Window edges: last forward, both ends of the dropped band, old packets
    send_ahead(SeqNoW'(HalfSpace - 1), 1'b0);
    send_ahead(SeqNoW'(HalfSpace), 1'b0);
    send_ahead(SeqNoW'(RepeatLimit), 1'b0);
    send_ahead(SeqNoW'(RepeatLimit + 1), 1'b0);
    send_ahead(SeqNoW'(SeqSpace - 1), 1'b0);
    // Start marker again does not reset the pointer
    send_ahead(2, 1'b1);
    send_ahead(0, 1'b1);
    send_ahead(SeqNoW'(SeqSpace - 1), 1'b1);
    pkt = '{seq_no: 16'hFFFF, start_flag: 1'b1};
    send_packet(pkt);
    pkt = '{seq_no: 16'h0000, start_flag: 1'b0};
    send_packet(pkt);
    send_ahead(1, 1'b0);
    send_ahead(0, 1'b0);

    // Random traffic in blocks with varying idle behavior
    for (int unsigned i = 0; i < RandomPackets; i++) begin
      if (i % 150 == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      if (i == 500) begin
        send_idle = 1'b0;
        long_hold = 1'b1;
      end
      if (i == 900) begin
        // Pause the sender until every ack is back
        @(negedge clk_i);
        in_valid <= 1'b0;
        while (acks.pending() != 0) @(posedge clk_i);
      end
      send_packet(draw_packet());
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (acks.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    acks.close();
    if (acks.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
